[design/ihex_pkg.sv]
// Shared types, constants and character helpers for the Intel HEX record encoder.
package ihex_pkg;

  // Default number of data bytes in one record
  localparam int RECORD_BYTES_DEF = 16;
  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // ASCII characters used in the text
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_F_UC  = 8'h46;
  // Offset from a nibble of 10..15 to lowercase 'a'..'f'
  localparam logic [7:0] CHAR_ALPHA_OFS = 8'h57;

  // Character slots of one transaction's text, in emission order
  typedef logic [4:0] ch_idx_t;
  localparam ch_idx_t CH_COLON     = 5'd0;
  localparam ch_idx_t CH_LEN_HI    = 5'd1;
  localparam ch_idx_t CH_LEN_LO    = 5'd2;
  localparam ch_idx_t CH_ADDR_3    = 5'd3;
  localparam ch_idx_t CH_ADDR_2    = 5'd4;
  localparam ch_idx_t CH_ADDR_1    = 5'd5;
  localparam ch_idx_t CH_ADDR_0    = 5'd6;
  localparam ch_idx_t CH_TYPE_HI   = 5'd7;
  localparam ch_idx_t CH_TYPE_LO   = 5'd8;
  localparam ch_idx_t CH_DATA_HI   = 5'd9;
  localparam ch_idx_t CH_DATA_LO   = 5'd10;
  localparam ch_idx_t CH_CHK_HI    = 5'd11;
  localparam ch_idx_t CH_CHK_LO    = 5'd12;
  localparam ch_idx_t CH_REC_CR    = 5'd13;
  localparam ch_idx_t CH_EOF_FIRST = 5'd14;
  localparam ch_idx_t CH_EOF_LAST  = 5'd24;
  localparam ch_idx_t CH_END_CR1   = 5'd25;
  localparam ch_idx_t CH_END_CR2   = 5'd26;

  // Input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_item;
  } ihex_in_t;

  // Output transaction
  typedef struct packed {
    logic [7:0] text_char;
    logic       run_end;
  } ihex_out_t;

  // Work for the back end, one per accepted input byte
  typedef struct packed {
    logic        hdr;   // emit the record header first
    logic        tail;  // emit checksum and CR after the data
    logic        eof;   // emit the end-of-file record after the tail
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  chk;
  } ihex_cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } ihex_qstat_t;

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'd0, nib};
    hex_char = (nib < 4'd10) ? (CHAR_ZERO + n8) : (CHAR_ALPHA_OFS + n8);
  endfunction

  // Characters of ":00000001FF"
  function automatic logic [7:0] eof_char(input logic [3:0] k);
    case (k)
      4'd0:    eof_char = CHAR_COLON;
      4'd8:    eof_char = CHAR_ONE;
      4'd9:    eof_char = CHAR_F_UC;
      4'd10:   eof_char = CHAR_F_UC;
      default: eof_char = CHAR_ZERO;
    endcase
  endfunction

endpackage

[design/ihex_front.sv]
// Front end: accepts bytes, tracks record position, address and checksum.
module ihex_front #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  ihex_pkg::ihex_in_t  src_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  ihex_pkg::ihex_qstat_t qstat,
  output logic                push,
  output ihex_pkg::ihex_cmd_t push_cmd
);

  localparam int PW = $clog2(RECORD_BYTES + 1);
  localparam logic [PW-1:0] POS_END = PW'(RECORD_BYTES);
  localparam logic [7:0]    LEN     = 8'(RECORD_BYTES);
  localparam logic [15:0]   STRIDE  = 16'(RECORD_BYTES);

  logic [15:0]   base_address;
  logic [15:0]   record_address;
  logic [PW-1:0] byte_position;
  logic [7:0]    running_sum;

  logic          hdr;
  logic [7:0]    sum_base;
  logic [7:0]    sum_next;
  logic [PW-1:0] pos_next;
  logic          tail;

  // Stall while the queue has no room
  assign src_stall = qstat.full;
  assign push      = src_valid && !qstat.full;

  // Classify the byte and fold it into the checksum
  always_comb begin
    hdr      = (byte_position == '0);
    sum_base = hdr ? (LEN + record_address[15:8] + record_address[7:0]) : running_sum;
    sum_next = sum_base + src_item.data_byte;
    pos_next = byte_position + PW'(1);
    tail     = (pos_next == POS_END);
    push_cmd.hdr  = hdr;
    push_cmd.tail = tail;
    push_cmd.eof  = tail && src_item.final_item;
    push_cmd.addr = record_address;
    push_cmd.data = src_item.data_byte;
    push_cmd.chk  = 8'd0 - sum_next;
  end

  // Advance record state; a config write restarts at the new base
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address   <= '0;
      record_address <= '0;
      byte_position  <= '0;
      running_sum    <= '0;
    end else if (cfg_we) begin
      base_address   <= cfg_data;
      record_address <= cfg_data;
      byte_position  <= '0;
      running_sum    <= '0;
    end else if (push) begin
      if (tail) begin
        byte_position  <= '0;
        running_sum    <= '0;
        record_address <= src_item.final_item ? base_address : (record_address + STRIDE);
      end else begin
        byte_position <= pos_next;
        running_sum   <= sum_next;
      end
    end
  end

endmodule

[design/ihex_queue.sv]
// Short command queue between the front and back ends.
module ihex_queue #(
  parameter int DEPTH = ihex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ihex_pkg::ihex_cmd_t   push_cmd,
  input  logic                  pop,
  output ihex_pkg::ihex_cmd_t   head_cmd,
  output ihex_pkg::ihex_qstat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  ihex_pkg::ihex_cmd_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign qstat.full  = (count == FULL_CNT);
  assign qstat.empty = (count == '0);
  assign head_cmd    = slots[rd_ptr];

  // Store an entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : (wr_ptr + AW'(1));
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : (rd_ptr + AW'(1));
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue occupancy beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("pop from an empty queue");

endmodule

[design/ihex_back.sv]
// Back end: walks each command's character slots into the output register.
module ihex_back #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ihex_pkg::ihex_cmd_t   head_cmd,
  input  ihex_pkg::ihex_qstat_t qstat,
  output logic                  pop,
  output logic                  dst_valid,
  input  logic                  dst_stall,
  output ihex_pkg::ihex_out_t   dst_item
);

  localparam logic [7:0] LEN = 8'(RECORD_BYTES);

  ihex_pkg::ch_idx_t idx;
  logic              started;
  ihex_pkg::ch_idx_t cur;
  ihex_pkg::ch_idx_t eof_ofs;
  logic [7:0]        ch;
  logic              last;
  logic              advance;
  logic              emit;

  assign advance = !dst_valid || !dst_stall;
  assign emit    = advance && !qstat.empty;
  assign pop     = emit && last;

  // Pick the slot and its character
  always_comb begin
    cur = started ? idx : (head_cmd.hdr ? ihex_pkg::CH_COLON : ihex_pkg::CH_DATA_HI);
    eof_ofs = cur - ihex_pkg::CH_EOF_FIRST;
    case (cur) inside
      ihex_pkg::CH_COLON:   ch = ihex_pkg::CHAR_COLON;
      ihex_pkg::CH_LEN_HI:  ch = ihex_pkg::hex_char(LEN[7:4]);
      ihex_pkg::CH_LEN_LO:  ch = ihex_pkg::hex_char(LEN[3:0]);
      ihex_pkg::CH_ADDR_3:  ch = ihex_pkg::hex_char(head_cmd.addr[15:12]);
      ihex_pkg::CH_ADDR_2:  ch = ihex_pkg::hex_char(head_cmd.addr[11:8]);
      ihex_pkg::CH_ADDR_1:  ch = ihex_pkg::hex_char(head_cmd.addr[7:4]);
      ihex_pkg::CH_ADDR_0:  ch = ihex_pkg::hex_char(head_cmd.addr[3:0]);
      ihex_pkg::CH_TYPE_HI: ch = ihex_pkg::CHAR_ZERO;
      ihex_pkg::CH_TYPE_LO: ch = ihex_pkg::CHAR_ZERO;
      ihex_pkg::CH_DATA_HI: ch = ihex_pkg::hex_char(head_cmd.data[7:4]);
      ihex_pkg::CH_DATA_LO: ch = ihex_pkg::hex_char(head_cmd.data[3:0]);
      ihex_pkg::CH_CHK_HI:  ch = ihex_pkg::hex_char(head_cmd.chk[7:4]);
      ihex_pkg::CH_CHK_LO:  ch = ihex_pkg::hex_char(head_cmd.chk[3:0]);
      ihex_pkg::CH_REC_CR:  ch = ihex_pkg::CHAR_CR;
      [ihex_pkg::CH_EOF_FIRST:ihex_pkg::CH_EOF_LAST]: ch = ihex_pkg::eof_char(eof_ofs[3:0]);
      ihex_pkg::CH_END_CR1: ch = ihex_pkg::CHAR_CR;
      ihex_pkg::CH_END_CR2: ch = ihex_pkg::CHAR_CR;
      default:              ch = ihex_pkg::CHAR_CR;
    endcase
    last = ((cur == ihex_pkg::CH_DATA_LO) && !head_cmd.tail) ||
           ((cur == ihex_pkg::CH_REC_CR) && !head_cmd.eof) ||
           (cur == ihex_pkg::CH_END_CR2);
  end

  // Step through slots; drop the command after its last character
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      idx     <= ihex_pkg::CH_COLON;
    end else if (emit) begin
      if (last) begin
        started <= 1'b0;
      end else begin
        started <= 1'b1;
        idx     <= cur + 5'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dst_item.text_char <= ch;
      dst_item.run_end   <= last;
    end
  end

endmodule

[design/intel_hex_record_encoder.sv]
// Intel HEX record encoder top level: front end, command queue, back end.
//
// Each accepted byte becomes a run of ASCII characters, one per transaction on
// the output channel, the last one flagged by run_end: two hex digits for a
// plain byte, nine more header characters before the first byte of a record,
// checksum and CR after its last byte, and ":00000001FF" with two CRs when the
// final flag arrives on a record's last byte (up to 18 characters per byte, or
// 27 when a record holds a single byte).
// The back end emits one character per cycle while the output is not stalled,
// into a single output register; a byte in mid-record has 2 characters. A
// two-entry queue lets the input take the next byte while earlier ones are
// still being spelled out. Writing
// the base address restarts at a fresh record; write it only while idle.
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF,
  parameter int QUEUE_DEPTH  = ihex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  ihex_pkg::ihex_in_t  src_item,
  output logic                dst_valid,
  input  logic                dst_stall,
  output ihex_pkg::ihex_out_t dst_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);

  logic                  push;
  logic                  pop;
  ihex_pkg::ihex_cmd_t   push_cmd;
  ihex_pkg::ihex_cmd_t   head_cmd;
  ihex_pkg::ihex_qstat_t qstat;

  ihex_front #(.RECORD_BYTES(RECORD_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  ihex_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .qstat    (qstat)
  );

  ihex_back #(.RECORD_BYTES(RECORD_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .qstat     (qstat),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

endmodule
